// File: rtl/utd_pkg.sv
// Package: shared types and constants for the UTF-8 to UTF-16 transcoder.
package utd_pkg;

    localparam logic [15:0] UNIT_REPL     = 16'hFFFD;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [20:0] CP_MIN_2B     = 21'h000080;
    localparam logic [20:0] CP_MIN_3B     = 21'h000800;
    localparam logic [20:0] CP_MIN_4B     = 21'h010000;
    localparam logic [15:0] UNIT_HI_SURR  = 16'hD800;
    localparam logic [15:0] UNIT_LO_SURR  = 16'hDC00;

    // Number of continuation bytes a lead byte announces
    localparam logic [1:0] EXP_NONE = 2'd0;
    localparam logic [1:0] EXP_ONE  = 2'd1;
    localparam logic [1:0] EXP_TWO  = 2'd2;
    localparam logic [1:0] EXP_THREE = 2'd3;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_string;
        logic        last_in_run;
    } res_t;

    // Results caused by one input byte, oldest in res0
    typedef struct packed {
        res_t       res0;
        res_t       res1;
        logic [1:0] count;
    } batch_t;

endpackage

// File: rtl/utf8_to_utf16_decoder_top.sv
// Top level: UTF-8 byte stream in, UTF-16 code units out.
//
// Input channel (in_valid/in_ready/in_byte) takes one UTF-8 byte per
// transaction; a zero byte terminates the string. Output channel
// (out_valid/out_ready) carries one result per transaction: code_unit,
// has_unit, end_of_string and last_in_run, the latter flagging the final
// result caused by a given byte.
// A byte is captured in an input register and decoded combinationally
// from it. Its results are loaded into the result register once that
// register has room, and the first result is then on the output.
// A byte yields zero, one or two results (two for a surrogate pair, or for
// a truncated sequence followed by a byte that itself gives a result).
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver is ready; a two-result byte holds the decoder until its
// first result has left, bounded by the one-result-per-cycle output port.
// Reset clears the pending sequence and empties both registers.
// When the receiver stalls, results wait in the result register and the
// input register fills, after which in_ready drops.
module utf8_to_utf16_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] code_unit,
    output logic        has_unit,
    output logic        end_of_string,
    output logic        last_in_run
);
    import utd_pkg::*;

    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg;
    logic       load_ok;
    logic       advance;
    batch_t     batch;
    res_t       head;

    // decoder moves when a byte is held and the result register has room
    assign advance  = byte_valid_reg && load_ok;
    assign in_ready = !byte_valid_reg || load_ok;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (in_valid && in_ready)
            byte_valid_next = 1'b1;
        else if (advance)
            byte_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else
            byte_valid_reg <= byte_valid_next;
    end

    // input payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    utd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (byte_reg),
        .batch   (batch)
    );

    utd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .batch     (batch),
        .out_ready (out_ready),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .head      (head)
    );

    assign code_unit     = head.code_unit;
    assign has_unit      = head.has_unit;
    assign end_of_string = head.end_of_string;
    assign last_in_run   = head.last_in_run;

endmodule

// File: rtl/utd_decode.sv
// Decoder: sequence state and per-byte decode into up to two results.
module utd_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      byte_in,
    output utd_pkg::batch_t batch
);
    import utd_pkg::*;

    logic [20:0] pp_reg, pp_next;
    logic [1:0]  expected_reg, expected_next;
    logic [1:0]  seen_reg, seen_next;

    // Fresh-byte decode
    logic        fr_emit;
    res_t        fr_res;
    logic [1:0]  fr_expected;
    logic [20:0] fr_pp;

    // Sequence completion
    logic [20:0] pp_shift;
    logic [1:0]  seen_inc;
    logic [20:0] fin_min;
    logic        fin_bad;
    logic        fin_pair;
    logic [19:0] fin_off;
    logic        is_cont;

    always_comb
    begin
        fr_emit     = 1'b0;
        fr_res      = '0;
        fr_expected = EXP_NONE;
        fr_pp       = '0;
        if (byte_in == 8'h00)
        begin
            fr_emit              = 1'b1;
            fr_res.end_of_string = 1'b1;
        end
        else if (byte_in[7] == 1'b0)
        begin
            fr_emit         = 1'b1;
            fr_res.code_unit = {8'h00, byte_in};
            fr_res.has_unit  = 1'b1;
        end
        else if (byte_in[7:5] == 3'b110)
        begin
            fr_expected = EXP_ONE;
            fr_pp       = {16'h0000, byte_in[4:0]};
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            fr_expected = EXP_TWO;
            fr_pp       = {17'h00000, byte_in[3:0]};
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            fr_expected = EXP_THREE;
            fr_pp       = {18'h00000, byte_in[2:0]};
        end
        else
        begin
            fr_emit          = 1'b1;
            fr_res.code_unit = UNIT_REPL;
            fr_res.has_unit  = 1'b1;
        end
    end

    assign is_cont  = (byte_in[7:6] == 2'b10);
    assign pp_shift = {pp_reg[14:0], byte_in[5:0]};
    assign seen_inc = seen_reg + 2'd1;

    always_comb
    begin
        unique case (expected_reg)
            EXP_ONE: fin_min = CP_MIN_2B;
            EXP_TWO: fin_min = CP_MIN_3B;
            default: fin_min = CP_MIN_4B;
        endcase
    end

    assign fin_bad  = (pp_shift < fin_min) || (pp_shift > CP_MAX) ||
                      ((pp_shift >= CP_SURR_LO) && (pp_shift <= CP_SURR_HI));
    assign fin_pair = (pp_shift >= CP_SUPP_BASE);
    assign fin_off  = 20'(pp_shift - CP_SUPP_BASE);

    always_comb
    begin
        pp_next       = pp_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        batch         = '0;
        if (expected_reg != EXP_NONE)
        begin
            if (is_cont)
            begin
                if (seen_inc >= expected_reg)
                begin
                    pp_next             = '0;
                    expected_next       = EXP_NONE;
                    seen_next           = '0;
                    batch.res0.has_unit = 1'b1;
                    batch.count         = 2'd1;
                    if (fin_bad)
                        batch.res0.code_unit = UNIT_REPL;
                    else if (fin_pair)
                    begin
                        batch.res0.code_unit = UNIT_HI_SURR + {6'h00, fin_off[19:10]};
                        batch.res1.code_unit = UNIT_LO_SURR + {6'h00, fin_off[9:0]};
                        batch.res1.has_unit  = 1'b1;
                        batch.count          = 2'd2;
                    end
                    else
                        batch.res0.code_unit = pp_shift[15:0];
                end
                else
                begin
                    pp_next   = pp_shift;
                    seen_next = seen_inc;
                end
            end
            else if (byte_in == 8'h00)
            begin
                pp_next                  = '0;
                expected_next            = EXP_NONE;
                seen_next                = '0;
                batch.res0.code_unit     = UNIT_REPL;
                batch.res0.has_unit      = 1'b1;
                batch.res0.end_of_string = 1'b1;
                batch.count              = 2'd1;
            end
            else
            begin
                // truncated sequence: replacement, then the byte taken afresh
                pp_next              = fr_pp;
                expected_next        = fr_expected;
                seen_next            = '0;
                batch.res0.code_unit = UNIT_REPL;
                batch.res0.has_unit  = 1'b1;
                batch.res1           = fr_res;
                batch.count          = fr_emit ? 2'd2 : 2'd1;
            end
        end
        else
        begin
            pp_next       = fr_pp;
            expected_next = fr_expected;
            seen_next     = '0;
            batch.res0    = fr_res;
            batch.count   = fr_emit ? 2'd1 : 2'd0;
        end
        if (batch.count == 2'd1)
            batch.res0.last_in_run = 1'b1;
        if (batch.count == 2'd2)
            batch.res1.last_in_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg       <= '0;
            expected_reg <= EXP_NONE;
            seen_reg     <= '0;
        end
        else if (advance)
        begin
            pp_reg       <= pp_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

// File: rtl/utd_outbuf.sv
// Result register: holds up to two results and hands them out in order.
module utd_outbuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  utd_pkg::batch_t batch,
    input  logic            out_ready,
    output logic            load_ok,
    output logic            out_valid,
    output utd_pkg::res_t   head
);
    import utd_pkg::*;

    res_t       r0_reg, r0_next;
    res_t       r1_reg, r1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = r0_reg;
    assign pop       = out_valid && out_ready;
    // room once the last held result leaves this cycle
    assign load_ok   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            r0_next  = batch.res0;
            r1_next  = batch.res1;
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            r0_next  = r1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

endmodule

// File: rtl/utd_checker.sv
// Checker: port-level assertions for the transcoder, bound to the top level.
module utd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_unit,
    input logic        has_unit,
    input logic        end_of_string,
    input logic        last_in_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_unit) &&
        $stable(has_unit) && $stable(end_of_string) && $stable(last_in_run))
        else $error("result changed while stalled");

    // bare end marker is a lone, zero result
    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_unit |-> end_of_string && last_in_run &&
        (code_unit == 16'h0000))
        else $error("malformed bare end marker");

    // end of string closes its byte's run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> last_in_run)
        else $error("end marker not last in run");

    // a high surrogate is always followed by its low half from the same byte
    a_hi_surr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_unit && (code_unit >= 16'hD800) && (code_unit <= 16'hDBFF)
        |-> !last_in_run && !end_of_string)
        else $error("high surrogate ends a run");

endmodule

bind utf8_to_utf16_decoder_top utd_checker u_utd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_unit     (code_unit),
    .has_unit      (has_unit),
    .end_of_string (end_of_string),
    .last_in_run   (last_in_run)
);
